>>> rtl/core/smma_pkg.sv
// Shared constants and types of the scaled matrix multiply-accumulate core.
// No dependencies; all other files reference this package by scoped names.
package smma_pkg;

    // Matrix size and derived widths
    localparam int DIM    = 8;
    localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ADDR_W = (DIM > 1) ? $clog2(DIM * DIM) : 1;
    localparam int ROW_W  = 3;
    localparam int COL_W  = 3;
    localparam int MODE_W = 2;
    localparam int DATA_W = 32;

    // Dot product (Q32.32 with growth) and scaled total (Q48.48 with growth)
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + ((DIM > 1) ? $clog2(DIM) : 0);
    localparam int HI_W   = SUM_W - DATA_W;
    localparam int TOT_W  = SUM_W + DATA_W + 1;

    // Sequencer timing, counted in advancing cycles from the compute word
    localparam int CNT_CAP   = 2 * DIM + 2;
    localparam int CNT_POST0 = CNT_CAP + 1;
    localparam int CNT_DONE  = 3 * DIM + 4;
    localparam int CNT_W     = $clog2(CNT_DONE + 1);

    // Word modes
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_C  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd3;

    // Register file
    localparam int   PADDR_W     = 3;
    localparam int   REG_SEL_BIT = 2;
    localparam logic REG_ALPHA   = 1'b0;
    localparam logic REG_BETA    = 1'b1;
    localparam logic [DATA_W-1:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] BETA_RESET  = 32'h0000_0000;

    // Saturation limits
    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // A operand traveling down the cell chain
    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         k;
        logic signed [DATA_W-1:0] a;
    } lane_t;

    // B element load into one cell's column store
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  k;
        logic [DATA_W-1:0] data;
    } bload_t;

    // Chain control
    typedef struct packed {
        logic adv;
        logic capture;
    } ctl_t;

    // C write-back from the scaling unit
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } wb_t;

endpackage

>>> rtl/core/smma_if.sv
// Request and result channel interfaces of the multiply-accumulate core.
// Depends on smma_pkg for field widths.
interface smma_req_if;
    logic                            valid;
    logic                            ready;
    logic [smma_pkg::MODE_W-1:0]     mode;
    logic [smma_pkg::ROW_W-1:0]      row_index;
    logic [smma_pkg::COL_W-1:0]      col_index;
    logic signed [smma_pkg::DATA_W-1:0] element_value;

    modport source (output valid, mode, row_index, col_index, element_value, input ready);
    modport sink   (input valid, mode, row_index, col_index, element_value, output ready);
endinterface

interface smma_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [smma_pkg::ROW_W-1:0]      out_row;
    logic [smma_pkg::COL_W-1:0]      out_col;
    logic signed [smma_pkg::DATA_W-1:0] out_value;
    logic                            last_of_row;

    modport source (output valid, out_row, out_col, out_value, last_of_row, input ready);
    modport sink   (input valid, out_row, out_col, out_value, last_of_row, output ready);
endinterface

>>> rtl/core/smma_cell.sv
// One multiply-accumulate cell: holds one column of B, one dot product.
// Depends on smma_pkg.
module smma_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smma_pkg::ctl_t        ctl,
    input  smma_pkg::bload_t      bload,
    input  smma_pkg::lane_t       lane_in,
    output smma_pkg::lane_t       lane_out,
    input  logic signed [smma_pkg::SUM_W-1:0] sum_in,
    output logic signed [smma_pkg::SUM_W-1:0] sum_out
);

    logic [smma_pkg::DATA_W-1:0]        b_mem [smma_pkg::DIM];

    logic                               v_reg;
    logic [smma_pkg::IDX_W-1:0]         k_reg;
    logic signed [smma_pkg::DATA_W-1:0] a_reg;
    logic signed [smma_pkg::DATA_W-1:0] b_reg;

    logic                               pv_reg;
    logic [smma_pkg::IDX_W-1:0]         pk_reg;
    logic signed [smma_pkg::PROD_W-1:0] prod_reg;

    logic signed [smma_pkg::SUM_W-1:0]  acc_reg;
    logic signed [smma_pkg::SUM_W-1:0]  acc_next;
    logic signed [smma_pkg::SUM_W-1:0]  prod_ext;
    logic signed [smma_pkg::SUM_W-1:0]  sh_reg;

    // column store of B, read at one row index per advancing cycle
    always_ff @(posedge clk)
    begin
        if (bload.we)
        begin
            b_mem[bload.k] <= bload.data;
        end
        if (ctl.adv)
        begin
            a_reg <= lane_in.a;
            k_reg <= lane_in.k;
            b_reg <= $signed(b_mem[lane_in.k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= 1'b0;
            pv_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            v_reg  <= lane_in.valid;
            pv_reg <= v_reg;
        end
    end

    assign prod_ext = smma_pkg::SUM_W'(prod_reg);
    // k == 0 opens a new dot product
    assign acc_next = (pk_reg == '0) ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            prod_reg <= a_reg * b_reg;
            pk_reg   <= k_reg;
            if (pv_reg)
            begin
                acc_reg <= acc_next;
            end
            sh_reg <= ctl.capture ? acc_reg : sum_in;
        end
    end

    assign lane_out.valid = v_reg;
    assign lane_out.k     = k_reg;
    assign lane_out.a     = a_reg;
    assign sum_out        = sh_reg;

endmodule

>>> rtl/core/smma_post.sv
// Scaling unit: alpha*sum + beta*C, truncate to Q16.16, saturate, result register.
// Depends on smma_pkg.
module smma_post (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic [smma_pkg::IDX_W-1:0]         in_col,
    input  logic signed [smma_pkg::SUM_W-1:0]  sum,
    input  logic signed [smma_pkg::DATA_W-1:0] c_old,
    input  logic signed [smma_pkg::DATA_W-1:0] alpha,
    input  logic signed [smma_pkg::DATA_W-1:0] beta,
    input  logic [smma_pkg::ROW_W-1:0]         row,
    output smma_pkg::wb_t                      wb,
    output logic                               out_valid,
    output logic [smma_pkg::ROW_W-1:0]         out_row,
    output logic [smma_pkg::COL_W-1:0]         out_col,
    output logic signed [smma_pkg::DATA_W-1:0] out_value,
    output logic                               out_last
);

    localparam int TW = smma_pkg::TOT_W;
    localparam int DW = smma_pkg::DATA_W;

    // stage 1: partial products
    logic                                  p1_v_reg;
    logic [smma_pkg::IDX_W-1:0]            p1_col_reg;
    logic signed [2*DW:0]                  p_lo_reg;
    logic signed [smma_pkg::SUM_W-1:0]     p_hi_reg;
    logic signed [2*DW-1:0]                p_c_reg;
    logic signed [smma_pkg::HI_W-1:0]      sum_hi;
    logic signed [DW:0]                    sum_lo;

    // stage 2: aligned total
    logic                                  p2_v_reg;
    logic [smma_pkg::IDX_W-1:0]            p2_col_reg;
    logic [TW-1:0]                         tot_reg;
    logic [TW-1:0]                         tot_next;

    logic [TW-2*DW:0]                      upper;
    logic [DW-1:0]                         sat_value;

    logic                                  o_v_reg;
    logic [smma_pkg::COL_W-1:0]            o_col_reg;
    logic [smma_pkg::ROW_W-1:0]            o_row_reg;
    logic [DW-1:0]                         o_val_reg;
    logic                                  o_last_reg;

    assign sum_hi = sum[smma_pkg::SUM_W-1:DW];
    assign sum_lo = $signed({1'b0, sum[DW-1:0]});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_lo_reg   <= alpha * sum_lo;
            p_hi_reg   <= alpha * sum_hi;
            p_c_reg    <= beta * c_old;
            p1_col_reg <= in_col;
        end
    end

    // sum = hi*2^32 + lo; old C term is Q32.32, aligned up by 16 to Q48.48
    assign tot_next = {{(TW-smma_pkg::SUM_W-DW){p_hi_reg[smma_pkg::SUM_W-1]}},
                       p_hi_reg, {DW{1'b0}}}
                    + {{(TW-2*DW-1){p_lo_reg[2*DW]}}, p_lo_reg}
                    + {{(TW-2*DW-16){p_c_reg[2*DW-1]}}, p_c_reg, 16'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tot_reg    <= tot_next;
            p2_col_reg <= p1_col_reg;
        end
    end

    // in range when every bit from 63 up matches the sign
    assign upper = tot_reg[TW-1:2*DW-1];

    always_comb
    begin
        if ((&upper) || !(|upper))
        begin
            sat_value = tot_reg[2*DW-1:DW];
        end
        else if (tot_reg[TW-1])
        begin
            sat_value = smma_pkg::Q_MIN;
        end
        else
        begin
            sat_value = smma_pkg::Q_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_col_reg  <= smma_pkg::COL_W'(p2_col_reg);
            o_row_reg  <= row;
            o_val_reg  <= sat_value;
            o_last_reg <= (p2_col_reg == smma_pkg::IDX_W'(smma_pkg::DIM - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else if (adv)
        begin
            p1_v_reg <= in_valid;
            p2_v_reg <= p1_v_reg;
            o_v_reg  <= p2_v_reg;
        end
    end

    // write-back happens as the result register loads
    assign wb.en    = adv && p2_v_reg;
    assign wb.col   = p2_col_reg;
    assign wb.value = sat_value;

    assign out_valid = o_v_reg;
    assign out_row   = o_row_reg;
    assign out_col   = o_col_reg;
    assign out_value = $signed(o_val_reg);
    assign out_last  = o_last_reg;

endmodule

>>> rtl/core/scaled_matrix_multiply_accumulate_core.sv
// Scaled matrix multiply-accumulate core, C = beta*C + alpha*(A*B), Q16.16.
// Depends on smma_pkg, smma_if, smma_cell, smma_post.
// Timing: load words are taken back to back while idle; a compute word's results
//   stream out one per cycle once the first is valid, while rsp does not stall.
// The next word is taken only after a compute word's chain walk and scaling are done.
// Reset: alpha = 1.0, beta = 0, pipeline empty; A, B, C stores are not cleared.
module scaled_matrix_multiply_accumulate_core (
    input  logic                               clk,
    input  logic                               rst_n,
    smma_req_if.sink                           req,
    smma_rsp_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [smma_pkg::PADDR_W-1:0]       paddr,
    input  logic [smma_pkg::DATA_W-1:0]        pwdata,
    output logic [smma_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int DIM = smma_pkg::DIM;
    localparam int AW  = smma_pkg::ADDR_W;
    localparam int IW  = smma_pkg::IDX_W;
    localparam int CW  = smma_pkg::CNT_W;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic [smma_pkg::DATA_W-1:0] alpha_reg;
    logic [smma_pkg::DATA_W-1:0] beta_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= smma_pkg::ALPHA_RESET;
            beta_reg  <= smma_pkg::BETA_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[smma_pkg::REG_SEL_BIT] == smma_pkg::REG_ALPHA)
            begin
                alpha_reg <= pwdata;
            end
            else
            begin
                beta_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[smma_pkg::REG_SEL_BIT] == smma_pkg::REG_BETA) ? beta_reg : alpha_reg;

    //------------------------------------------------------------------
    // Sequencer: idle takes words, run walks one row through the chain
    //------------------------------------------------------------------
    smma_pkg::state_t              state_reg;
    smma_pkg::state_t              state_next;
    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 cnt_next;
    logic [smma_pkg::ROW_W-1:0]    row_reg;
    logic                          accept;
    logic                          in_range;
    logic                          adv;
    logic                          running;
    logic                          ld_a;
    logic                          ld_b;
    logic                          ld_c;
    logic                          start;
    logic [AW-1:0]                 ld_addr;

    // the whole compute path moves only when the result register can take a word
    assign adv     = !rsp.valid || rsp.ready;
    assign running = (state_reg == smma_pkg::ST_RUN);

    assign req.ready = (state_reg == smma_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign in_range  = (32'(req.row_index) < DIM) && (32'(req.col_index) < DIM);
    assign ld_addr   = AW'(32'(req.row_index) * DIM + 32'(req.col_index));

    always_comb
    begin
        ld_a  = 1'b0;
        ld_b  = 1'b0;
        ld_c  = 1'b0;
        start = 1'b0;
        unique case (req.mode)
            smma_pkg::MODE_LOAD_A:  ld_a  = accept && in_range;
            smma_pkg::MODE_LOAD_B:  ld_b  = accept && in_range;
            smma_pkg::MODE_LOAD_C:  ld_c  = accept && in_range;
            smma_pkg::MODE_COMPUTE: start = accept && (32'(req.row_index) < DIM);
            default:                start = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            smma_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = smma_pkg::ST_RUN;
                    cnt_next   = '0;
                end
            end
            smma_pkg::ST_RUN:
            begin
                if (adv)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == CW'(smma_pkg::CNT_DONE))
                    begin
                        state_next = smma_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = smma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smma_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg <= req.row_index;
        end
    end

    //------------------------------------------------------------------
    // A store: row i is streamed out one element per advancing cycle into cell 0
    //------------------------------------------------------------------
    logic [smma_pkg::DATA_W-1:0] a_mem [DIM*DIM];
    logic [smma_pkg::DATA_W-1:0] a_q_reg;
    logic [IW-1:0]               aq_k_reg;
    logic                        aq_v_reg;
    logic                        a_re;
    logic [AW-1:0]               a_raddr;

    assign a_re    = running && adv && (cnt_reg < CW'(DIM));
    assign a_raddr = AW'(32'(row_reg) * DIM + 32'(cnt_reg));

    always_ff @(posedge clk)
    begin
        if (ld_a)
        begin
            a_mem[ld_addr] <= req.element_value;
        end
        if (a_re)
        begin
            a_q_reg  <= a_mem[a_raddr];
            aq_k_reg <= IW'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aq_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            aq_v_reg <= a_re;
        end
    end

    //------------------------------------------------------------------
    // Cell chain: cell j owns column j of B and forms C[i][j]'s dot product.
    // A[i][k] hops one cell per advancing cycle; once the last cell is done the sums
    // are captured and shift out toward cell 0, column 0 first.
    //------------------------------------------------------------------
    smma_pkg::lane_t                    lane [DIM+1];
    logic signed [smma_pkg::SUM_W-1:0]  sums [DIM+1];
    smma_pkg::ctl_t                     ctl;

    assign ctl.adv     = adv;
    assign ctl.capture = running && (cnt_reg == CW'(smma_pkg::CNT_CAP));

    assign lane[0].valid = aq_v_reg;
    assign lane[0].k     = aq_k_reg;
    assign lane[0].a     = $signed(a_q_reg);
    assign sums[DIM]     = '0;

    for (genvar j = 0; j < DIM; j++)
    begin : g_cell
        smma_pkg::bload_t bl;

        assign bl.we   = ld_b && (32'(req.col_index) == j);
        assign bl.k    = IW'(req.row_index);
        assign bl.data = req.element_value;

        smma_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .bload    (bl),
            .lane_in  (lane[j]),
            .lane_out (lane[j+1]),
            .sum_in   (sums[j+1]),
            .sum_out  (sums[j])
        );
    end

    //------------------------------------------------------------------
    // C store: old element read into c_q_reg to meet its sum at the scaling unit, new one written
    // back as the result register loads.
    //------------------------------------------------------------------
    logic [smma_pkg::DATA_W-1:0] c_mem [DIM*DIM];
    logic [smma_pkg::DATA_W-1:0] c_q_reg;
    logic                        c_re;
    logic [AW-1:0]               c_raddr;
    logic                        c_we;
    logic [AW-1:0]               c_waddr;
    logic [smma_pkg::DATA_W-1:0] c_wdata;
    smma_pkg::wb_t               wb;

    assign c_re    = running && adv && (cnt_reg >= CW'(smma_pkg::CNT_CAP))
                   && (cnt_reg < CW'(smma_pkg::CNT_CAP + DIM));
    assign c_raddr = AW'(32'(row_reg) * DIM + 32'(cnt_reg) - smma_pkg::CNT_CAP);

    assign c_we    = ld_c || wb.en;
    assign c_waddr = wb.en ? AW'(32'(row_reg) * DIM + 32'(wb.col)) : ld_addr;
    assign c_wdata = wb.en ? wb.value : req.element_value;

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            c_mem[c_waddr] <= c_wdata;
        end
        if (c_re)
        begin
            c_q_reg <= c_mem[c_raddr];
        end
    end

    //------------------------------------------------------------------
    // Scaling, truncation, saturation and result register
    //------------------------------------------------------------------
    logic          post_v;
    logic [IW-1:0] post_col;

    assign post_v   = running && (cnt_reg >= CW'(smma_pkg::CNT_POST0))
                    && (cnt_reg < CW'(smma_pkg::CNT_POST0 + DIM));
    assign post_col = IW'(cnt_reg - CW'(smma_pkg::CNT_POST0));

    smma_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (post_v),
        .in_col    (post_col),
        .sum       (sums[0]),
        .c_old     ($signed(c_q_reg)),
        .alpha     ($signed(alpha_reg)),
        .beta      ($signed(beta_reg)),
        .row       (row_reg),
        .wb        (wb),
        .out_valid (rsp.valid),
        .out_row   (rsp.out_row),
        .out_col   (rsp.out_col),
        .out_value (rsp.out_value),
        .out_last  (rsp.last_of_row)
    );

endmodule

>>> test/scaled_matrix_multiply_accumulate_core_tb.sv
// Self-checking testbench of scaled_matrix_multiply_accumulate_core.
// Depends on smma_pkg, smma_req_if, smma_rsp_if and the core itself.
// Drives load/compute words and checks each C word against its own GEMM predictor.
module scaled_matrix_multiply_accumulate_core_tb;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int DIM     = smma_pkg::DIM;
    localparam int PADDR_W = smma_pkg::PADDR_W;
    localparam int DATA_W  = smma_pkg::DATA_W;
    localparam int ROW_W   = smma_pkg::ROW_W;
    localparam int COL_W   = smma_pkg::COL_W;
    localparam int MODE_W  = smma_pkg::MODE_W;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = smma_pkg::MODE_LOAD_A;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = smma_pkg::MODE_LOAD_B;
    localparam logic [MODE_W-1:0] MODE_LOAD_C  = smma_pkg::MODE_LOAD_C;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = smma_pkg::MODE_COMPUTE;

    localparam logic [DATA_W-1:0] Q_MAX       = smma_pkg::Q_MAX;
    localparam logic [DATA_W-1:0] Q_MIN       = smma_pkg::Q_MIN;
    localparam logic [DATA_W-1:0] ALPHA_RESET = smma_pkg::ALPHA_RESET;
    localparam logic [DATA_W-1:0] BETA_RESET  = smma_pkg::BETA_RESET;

    localparam int N_CELLS = DIM * DIM;

    // A and C are filled on these leading rows only; computes stay on them
    localparam int FILL_ROWS = 4;

    // Register byte addresses: register i at 4*i
    localparam logic [PADDR_W-1:0] ADDR_ALPHA = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_BETA  = 3'd4;

    // Gain encodings used by the sweep, Q16.16
    localparam logic [DATA_W-1:0] GAIN_ONE      = 32'h0001_0000;
    localparam logic [DATA_W-1:0] GAIN_HALF     = 32'h0000_8000;
    localparam logic [DATA_W-1:0] GAIN_MINUS_1  = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] GAIN_ZERO     = 32'h0000_0000;

    // Saturation bounds in the wide predictor domain
    localparam logic signed [127:0] WIDE_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] WIDE_MIN = -128'sh8000_0000;

    // Outlasts a compute word's run in the core; pad after draining, before a gain write
    localparam int DRAIN_PAUSE = 3 * DIM + 16;

    // Slowest gap: the receiver hold-off plus a compute word, taken several times
    localparam int RSP_HOLD    = 400;
    localparam int STALL_LIMIT = 4000;

    // One emitted C word
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              last;
    } c_word_t;

    // ------------------------------------------------------------------
    // Clock, reset, channels, APB
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    smma_req_if req_ch ();
    smma_rsp_if rsp_ch ();

    scaled_matrix_multiply_accumulate_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: matrix stores and gains as the core should hold them
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] a_mat [N_CELLS];
    logic signed [DATA_W-1:0] b_mat [N_CELLS];
    logic signed [DATA_W-1:0] c_mat [N_CELLS];
    logic signed [DATA_W-1:0] alpha_q;
    logic signed [DATA_W-1:0] beta_q;

    c_word_t pending_c_words [$];

    int  mismatch_count;
    int  words_sent;
    int  rows_computed;
    int  results_checked;
    int  idle_cycles;
    int  rsp_hold_left;
    bit  calm;          // no random idling on either side while set

    // New C element: alpha*(A row . B col) + beta*C, Q48.48, floor to Q16.16, saturate
    function automatic logic [DATA_W-1:0] gemm_element(int r, int c);
        logic signed [63:0]  prod;
        logic signed [63:0]  old_prod;
        logic signed [127:0] dot;
        logic signed [127:0] total;
        logic signed [127:0] old_w;
        logic signed [127:0] q16;
        dot = '0;
        for (int k = 0; k < DIM; k++)
        begin
            prod = a_mat[r * DIM + k] * b_mat[k * DIM + c];
            dot  = dot + prod;
        end
        old_prod = beta_q * c_mat[r * DIM + c];
        old_w    = old_prod;
        total    = dot * alpha_q + (old_w <<< 16);
        q16      = total >>> 32;
        if (q16 > WIDE_MAX)
            return Q_MAX;
        if (q16 < WIDE_MIN)
            return Q_MIN;
        return q16[DATA_W-1:0];
    endfunction

    // Apply one accepted word to the predictor and queue its C words
    task automatic predict_word(logic [MODE_W-1:0] mode, int r, int c, logic [DATA_W-1:0] v);
        c_word_t cw;
        logic [DATA_W-1:0] row_vals [DIM];
        if (mode == MODE_COMPUTE)
        begin
            if (r < DIM)
            begin
                // all columns use the old C row, so compute before write-back
                for (int j = 0; j < DIM; j++)
                    row_vals[j] = gemm_element(r, j);
                for (int j = 0; j < DIM; j++)
                begin
                    c_mat[r * DIM + j] = row_vals[j];
                    cw.row   = r[ROW_W-1:0];
                    cw.col   = j[COL_W-1:0];
                    cw.value = row_vals[j];
                    cw.last  = (j == DIM - 1);
                    pending_c_words.push_back(cw);
                end
                rows_computed++;
            end
        end
        else if (r < DIM && c < DIM)
        begin
            case (mode)
                MODE_LOAD_A: a_mat[r * DIM + c] = v;
                MODE_LOAD_B: b_mat[r * DIM + c] = v;
                default:     c_mat[r * DIM + c] = v;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Request side: send one word; valid stays high for a back-to-back word
    // ------------------------------------------------------------------
    task automatic send_word(logic [MODE_W-1:0] mode, int r, int c, logic [DATA_W-1:0] v);
        if (!calm && $urandom_range(99) < 20)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= mode;
        req_ch.row_index     <= r[ROW_W-1:0];
        req_ch.col_index     <= c[COL_W-1:0];
        req_ch.element_value <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        words_sent++;
        predict_word(mode, r, c, v);
    endtask

    // Sender pause: drop valid, wait until every queued C word came back, then wait DRAIN_PAUSE
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_c_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Mixed element values: extremes, small Q16.16 magnitudes, full-range noise
    function automatic logic [DATA_W-1:0] rand_element();
        int pick;
        int small_v;
        pick = $urandom_range(9);
        if (pick == 0)
            return Q_MAX;
        if (pick == 1)
            return Q_MIN;
        if (pick < 6)
        begin
            small_v = $urandom_range(0, 1 << 19) - (1 << 18);
            return small_v;
        end
        return $urandom();
    endfunction

    // Loads go anywhere; computes only on rows whose A and C are filled
    task automatic send_random_word(int compute_pct);
        logic [MODE_W-1:0] m;
        int                r;
        if ($urandom_range(99) < compute_pct)
        begin
            m = MODE_COMPUTE;
            r = $urandom_range(FILL_ROWS - 1);
        end
        else
        begin
            m = MODE_W'($urandom_range(2));
            r = $urandom_range(DIM - 1);
        end
        send_word(m, r, $urandom_range(DIM - 1), rand_element());
    endtask

    // ------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------
    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(logic [PADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_gain(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;
        apb_read(addr, got);
        if (got !== want)
        begin
            $display("%0t: gain reg @%0d expected %h got %h", $time, addr, want, got);
            mismatch_count++;
        end
    endtask

    // Only called with the core idle
    task automatic set_gains(logic [DATA_W-1:0] alpha, logic [DATA_W-1:0] beta);
        wait_drained();
        apb_write(ADDR_ALPHA, alpha);
        apb_write(ADDR_BETA, beta);
        alpha_q = alpha;
        beta_q  = beta;
        check_gain(ADDR_ALPHA, alpha);
        check_gain(ADDR_BETA, beta);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_reset();
        check_gain(ADDR_ALPHA, ALPHA_RESET);
        check_gain(ADDR_BETA, BETA_RESET);
    endtask

    // All of B, and A and C on the rows that computes use, before any compute
    task automatic test_fill_stores();
        for (int i = 0; i < N_CELLS; i++)
            send_word(MODE_LOAD_B, i / DIM, i % DIM, rand_element());
        for (int i = 0; i < FILL_ROWS * DIM; i++)
        begin
            send_word(MODE_LOAD_A, i / DIM, i % DIM, rand_element());
            send_word(MODE_LOAD_C, i / DIM, i % DIM, rand_element());
        end
    endtask

    // Reset gains, then saturation at the top and at the bottom of the range
    task automatic test_directed_saturation();
        send_word(MODE_COMPUTE, 0, 0, '0);
        for (int k = 0; k < DIM; k++)
            send_word(MODE_LOAD_B, k, 0, Q_MAX);
        for (int k = 0; k < DIM; k++)
            send_word(MODE_LOAD_A, 1, k, Q_MAX);
        // compute ignores col and element fields; drive them non-zero
        send_word(MODE_COMPUTE, 1, DIM - 1, Q_MIN);
        for (int k = 0; k < DIM; k++)
            send_word(MODE_LOAD_A, 2, k, Q_MIN);
        send_word(MODE_COMPUTE, 2, 5, Q_MAX);
    endtask

    // Gain extremes and typical settings, each with a short burst of traffic
    task automatic test_gain_sweep();
        logic [DATA_W-1:0] alphas [5];
        logic [DATA_W-1:0] betas  [5];
        alphas = '{Q_MAX, Q_MIN, GAIN_HALF, GAIN_ZERO, $urandom()};
        betas  = '{Q_MIN, Q_MAX, GAIN_ONE, GAIN_MINUS_1, $urandom()};
        for (int s = 0; s < 5; s++)
        begin
            set_gains(alphas[s], betas[s]);
            for (int n = 0; n < 5; n++)
                send_random_word(40);
        end
    endtask

    // Receiver holds off while the sender keeps offering; the core must back up
    task automatic test_backpressure();
        set_gains(GAIN_HALF, GAIN_HALF);
        rsp_hold_left = RSP_HOLD;
        send_word(MODE_COMPUTE, 0, 0, '0);
        for (int n = 0; n < 12; n++)
            send_random_word(50);
        wait_drained();
    endtask

    // Random loads and computes; a calm stretch in the middle, random gains late on
    task automatic test_random_traffic();
        set_gains(GAIN_ONE, GAIN_HALF);
        for (int n = 0; n < 45; n++)
        begin
            calm = (n >= 10 && n < 32);
            if (n == 36)
                set_gains($urandom(), $urandom_range(0, 1 << 17) - (1 << 16));
            send_random_word(25);
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls, plus a long hold-off counted here
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_left--;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    // Compare each accepted C word with the oldest expectation
    always @(posedge clk)
    begin
        c_word_t exp_w;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_c_words.size() == 0)
            begin
                $display("%0t: unexpected word row %0d col %0d value %h", $time,
                         rsp_ch.out_row, rsp_ch.out_col, rsp_ch.out_value);
                mismatch_count++;
            end
            else
            begin
                exp_w = pending_c_words.pop_front();
                results_checked++;
                if (rsp_ch.out_row !== exp_w.row)
                begin
                    $display("%0t: out_row expected %0d got %0d", $time,
                             exp_w.row, rsp_ch.out_row);
                    mismatch_count++;
                end
                if (rsp_ch.out_col !== exp_w.col)
                begin
                    $display("%0t: out_col expected %0d got %0d", $time,
                             exp_w.col, rsp_ch.out_col);
                    mismatch_count++;
                end
                if (rsp_ch.out_value !== exp_w.value)
                begin
                    $display("%0t: out_value (row %0d col %0d) expected %h got %h", $time,
                             exp_w.row, exp_w.col, exp_w.value, rsp_ch.out_value);
                    mismatch_count++;
                end
                if (rsp_ch.last_of_row !== exp_w.last)
                begin
                    $display("%0t: last_of_row expected %b got %b", $time,
                             exp_w.last, rsp_ch.last_of_row);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any word moving on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d words outstanding", $time,
                     STALL_LIMIT, pending_c_words.size());
            $display("scaled_matrix_multiply_accumulate_core_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        mismatch_count  = 0;
        words_sent      = 0;
        rows_computed   = 0;
        results_checked = 0;
        idle_cycles     = 0;
        rsp_hold_left   = 0;
        calm            = 1'b0;
        alpha_q         = ALPHA_RESET;
        beta_q          = BETA_RESET;
        for (int i = 0; i < N_CELLS; i++)
        begin
            a_mat[i] = '0;
            b_mat[i] = '0;
            c_mat[i] = '0;
        end

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_LOAD_A;
        req_ch.row_index     = '0;
        req_ch.col_index     = '0;
        req_ch.element_value = '0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_fill_stores();
        test_directed_saturation();
        test_gain_sweep();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (pending_c_words.size() != 0)
        begin
            $display("%0t: %0d C words never arrived", $time, pending_c_words.size());
            mismatch_count++;
        end

        $display("Sent %0d words (%0d row computes), checked %0d C words, %0d mismatches",
                 words_sent, rows_computed, results_checked, mismatch_count);
        $display("Covered gain extremes, saturation both ways, output back-pressure, random mix");
        if (mismatch_count == 0)
            $display("scaled_matrix_multiply_accumulate_core_tb OK");
        else
            $display("scaled_matrix_multiply_accumulate_core_tb NOT OK");
        $finish;
    end

endmodule
